@@ hw/rtl/i2cs_pkg.sv @@
// Shared types and constants for the I2C bus address scanner.
// No dependencies; imported by i2cs_engine and the top level.
`timescale 1ns / 1ps

package i2cs_pkg;

    localparam int unsigned CfgAddrW   = 2;
    localparam int unsigned CfgDataW   = 16;
    localparam int unsigned AddrW      = 7;
    localparam int unsigned TicksW     = 16;
    localparam int unsigned BusSelW    = 2;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned InDataW    = 8;
    localparam int unsigned OutDataW   = 16;

    // register indexes on the configuration port
    localparam logic [CfgAddrW-1:0] REG_BUS_SELECT  = 2'd0;
    localparam logic [CfgAddrW-1:0] REG_PHASE_TICKS = 2'd1;
    localparam logic [CfgAddrW-1:0] REG_GAP_TICKS   = 2'd2;

    // bus selector codes
    localparam logic [BusSelW-1:0] BUS_ONE = 2'd1;
    localparam logic [BusSelW-1:0] BUS_TWO = 2'd2;

    localparam logic [BusSelW-1:0] BUS_SELECT_RESET  = BUS_ONE;
    localparam logic [TicksW-1:0]  PHASE_TICKS_RESET = 16'd25;
    localparam logic [TicksW-1:0]  GAP_TICKS_RESET   = 16'd250;

    localparam logic [AddrW-1:0] FIRST_ADDR = 7'd1;
    localparam logic [AddrW-1:0] LAST_ADDR  = 7'd127;

    typedef struct packed {
        logic [BusSelW-1:0] bus_select;
        logic [TicksW-1:0]  phase_ticks;
        logic [TicksW-1:0]  gap_ticks;
    } i2cs_cfg_t;

    typedef struct packed {
        logic             scan_done;
        logic [AddrW-1:0] found_address;
        logic             found_valid;
        logic             busy_res;
        logic             sda_bus2;
        logic             scl_bus2;
        logic             sda_bus1;
        logic             scl_bus1;
    } i2cs_result_t;

endpackage

@@ hw/rtl/i2c_bitbang_address_scanner_top.sv @@
// Top level of the bit-banged I2C address scanner: stream ports, configuration registers,
// input and result registers. Depends on i2cs_pkg and i2cs_engine.
//
//  channel  | ports                          | content
//  ---------+--------------------------------+---------------------------------------------
//  input    | s_tvalid s_tready s_tdata      | tdata[0] sda_in, tuser[0] req_type
//           | s_tuser                        | (0 = one tick, 1 = start a scan)
//  result   | m_tvalid m_tready m_tdata      | one result per input transfer
//  config   | cfg_we cfg_addr cfg_wdata      | 0 bus_select, 1 phase_ticks, 2 gap_ticks
//
// One transfer is taken every cycle unless the result side stalls; a result passes through the
// input register, then the sequencer step into the result register.
// The sequencer advances only when its item moves into the result register, so a stall on
// the result side holds both stages and drops s_tready once the input stage holds an item.
// aresetn is synchronous, active low; it idles the sequencer and loads the register defaults.
`timescale 1ns / 1ps

module i2c_bitbang_address_scanner_top
    import i2cs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // [0] sda_in, [7:1] zero
    input  logic                s_tuser,   // [0] req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] scl_bus1, [1] sda_bus1, [2] scl_bus2, [3] sda_bus2, [4] busy_res,
    // [5] found_valid, [12:6] found_address, [13] scan_done, [15:14] zero
    output logic [OutDataW-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata
);

    localparam int unsigned ResW = $bits(i2cs_result_t);

    i2cs_cfg_t          cfg_reg;
    logic               in_valid_reg;
    logic               in_req_reg;
    logic               in_sda_reg;
    logic               out_valid_reg;
    logic [ResW-1:0]    out_data_reg;
    i2cs_result_t       step_result;
    logic               out_ready;
    logic               step_en;

    assign out_ready = !out_valid_reg || m_tready;
    assign step_en   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bus_select  <= BUS_SELECT_RESET;
            cfg_reg.phase_ticks <= PHASE_TICKS_RESET;
            cfg_reg.gap_ticks   <= GAP_TICKS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_BUS_SELECT:  cfg_reg.bus_select  <= cfg_wdata[BusSelW-1:0];
                REG_PHASE_TICKS: cfg_reg.phase_ticks <= cfg_wdata[TicksW-1:0];
                REG_GAP_TICKS:   cfg_reg.gap_ticks   <= cfg_wdata[TicksW-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg <= s_tuser;
            in_sda_reg <= s_tdata[0];
        end
    end

    i2cs_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .req_type (in_req_reg),
        .sda_in   (in_sda_reg),
        .cfg      (cfg_reg),
        .result   (step_result)
    );

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW-ResW){1'b0}}, out_data_reg};

    // a found address comes only from a running scan and is never zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[5]) |-> (m_tdata[4] && m_tdata[12:6] != '0))
        else $error("found result without a running scan or with address zero");

    // the end-of-scan pulse leaves the block idle and never coincides with a find
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[13]) |-> (!m_tdata[4] && !m_tdata[5]))
        else $error("scan_done while still busy or with a find");

    // while bus 1 is selected, bus 2 stays released
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cfg_reg.bus_select == BUS_ONE) |-> (m_tdata[3:2] == 2'b11))
        else $error("bus 2 driven while bus 1 is selected");

    // a step happens only when an item sits in the input stage and leaves it
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> out_valid_reg)
        else $error("sequencer stepped without producing a result");

endmodule

@@ hw/rtl/i2cs_engine.sv @@
// Probe sequencer for the I2C address scanner: phase state, tick counter, shift register.
// Depends on i2cs_pkg. Advances one step per transfer handed over by the top level.
`timescale 1ns / 1ps

module i2cs_engine
    import i2cs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  logic         req_type,
    input  logic         sda_in,
    input  i2cs_cfg_t    cfg,
    output i2cs_result_t result
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_BIT_LO, PH_BIT_HI,
        PH_ACK_LO, PH_ACK_HI, PH_STOP_LO, PH_STOP_HI, PH_GAP
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [TicksW-1:0]  wait_reg, wait_next;
    logic [3:0]         bit_count_reg, bit_count_next;
    logic [AddrW-1:0]   addr_reg, addr_next;
    logic [ByteW-1:0]   shift_reg, shift_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;

    logic [TicksW:0]    cnt;
    logic [TicksW:0]    len;
    logic               found;
    logic               done;
    logic [3:0]         bit_inc;

    assign cnt     = {1'b0, wait_reg} + {{TicksW{1'b0}}, 1'b1};
    assign bit_inc = bit_count_reg + 4'd1;

    always_comb begin
        priority if (phase_reg == PH_GAP) begin
            len = {1'b0, cfg.gap_ticks};
        end else if (cfg.phase_ticks == '0) begin
            len = {{TicksW{1'b0}}, 1'b1};
        end else begin
            len = {1'b0, cfg.phase_ticks};
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        bit_count_next = bit_count_reg;
        addr_next      = addr_reg;
        shift_next     = shift_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        found          = 1'b0;
        done           = 1'b0;

        if (req_type) begin
            if (phase_reg == PH_IDLE) begin
                addr_next      = FIRST_ADDR;
                shift_next     = {FIRST_ADDR, 1'b0};
                phase_next     = PH_START_A;
                scl_next       = 1'b1;
                sda_next       = 1'b1;
                wait_next      = '0;
                bit_count_next = '0;
            end
        end else if (phase_reg != PH_IDLE) begin
            if (cnt < len) begin
                wait_next = cnt[TicksW-1:0];
            end else begin
                wait_next = '0;
                unique case (phase_reg)
                    PH_START_A: begin
                        phase_next = PH_START_B;
                        sda_next   = 1'b0;
                    end
                    PH_START_B: begin
                        phase_next     = PH_BIT_LO;
                        scl_next       = 1'b0;
                        bit_count_next = '0;
                        sda_next       = shift_reg[ByteW-1];
                    end
                    PH_BIT_LO: begin
                        phase_next = PH_BIT_HI;
                        scl_next   = 1'b1;
                    end
                    PH_BIT_HI: begin
                        shift_next     = {shift_reg[ByteW-2:0], 1'b0};
                        bit_count_next = bit_inc;
                        scl_next       = 1'b0;
                        if (bit_inc >= 4'd8) begin
                            phase_next = PH_ACK_LO;
                            sda_next   = 1'b1;
                        end else begin
                            phase_next = PH_BIT_LO;
                            sda_next   = shift_reg[ByteW-2];
                        end
                    end
                    PH_ACK_LO: begin
                        phase_next = PH_ACK_HI;
                        scl_next   = 1'b1;
                    end
                    PH_ACK_HI: begin
                        // unused selector codes read the ack as high
                        found = (cfg.bus_select == BUS_ONE || cfg.bus_select == BUS_TWO)
                                && !sda_in;
                        phase_next = PH_STOP_LO;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end
                    PH_STOP_LO: begin
                        phase_next = PH_STOP_HI;
                        scl_next   = 1'b1;
                    end
                    PH_STOP_HI, PH_GAP: begin
                        sda_next = 1'b1;
                        if (phase_reg == PH_STOP_HI && cfg.gap_ticks != '0) begin
                            phase_next = PH_GAP;
                        end else begin
                            // end of probe: stop after the last address, else move on
                            scl_next = 1'b1;
                            if (addr_reg >= LAST_ADDR) begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end else begin
                                addr_next      = addr_reg + 7'd1;
                                shift_next     = {addr_next, 1'b0};
                                phase_next     = PH_START_A;
                                bit_count_next = '0;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            wait_reg      <= '0;
            bit_count_reg <= '0;
            addr_reg      <= FIRST_ADDR;
            shift_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            bit_count_reg <= bit_count_next;
            addr_reg      <= addr_next;
            shift_reg     <= shift_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
        end
    end

    always_comb begin
        result.scl_bus1      = (cfg.bus_select == BUS_ONE) ? scl_next : 1'b1;
        result.sda_bus1      = (cfg.bus_select == BUS_ONE) ? sda_next : 1'b1;
        result.scl_bus2      = (cfg.bus_select == BUS_TWO) ? scl_next : 1'b1;
        result.sda_bus2      = (cfg.bus_select == BUS_TWO) ? sda_next : 1'b1;
        result.busy_res      = (phase_next != PH_IDLE);
        result.found_valid   = found;
        result.found_address = found ? addr_reg : '0;
        result.scan_done     = done;
    end

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for i2c_bitbang_address_scanner_top: random tick/start traffic,
// bus-level prediction per tick, field-by-field result checking.
// Depends on i2cs_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module tb_top;
    import i2cs_pkg::*;

    localparam int unsigned ResW        = $bits(i2cs_result_t);
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned HOLD_AT     = 1000;
    localparam int unsigned HOLD_LEN    = 400;
    localparam int unsigned MAX_LINES   = 100;

    // selector codes that drive neither bus
    localparam logic [BusSelW-1:0] BUS_OFF_LOW  = 2'd0;
    localparam logic [BusSelW-1:0] BUS_OFF_HIGH = 2'd3;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_START_A, SQ_START_B, SQ_BIT_LO, SQ_BIT_HI,
        SQ_ACK_LO, SQ_ACK_HI, SQ_STOP_LO, SQ_STOP_HI, SQ_GAP
    } seq_phase_e;

    typedef struct packed {
        logic req;
        logic sda;
    } scan_req_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata   = '0;   // [0] sda_in, [7:1] zero
    logic                s_tuser   = 1'b0; // [0] req_type
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // [0] scl_bus1, [1] sda_bus1, [2] scl_bus2, [3] sda_bus2, [4] busy_res,
    // [5] found_valid, [12:6] found_address, [13] scan_done, [15:14] zero
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_we    = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr  = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;

    i2c_bitbang_address_scanner_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // scanner copy: configuration and sequencer state
    logic [BusSelW-1:0] sel_bus   = BUS_SELECT_RESET;
    logic [TicksW-1:0]  phase_len = PHASE_TICKS_RESET;
    logic [TicksW-1:0]  gap_len   = GAP_TICKS_RESET;
    seq_phase_e         sq_phase  = SQ_IDLE;
    logic [TicksW-1:0]  hold_cnt  = '0;
    logic [3:0]         bit_cnt   = '0;
    logic [AddrW-1:0]   probe_addr = FIRST_ADDR;
    logic [ByteW-1:0]   addr_byte = '0;
    logic               scl_lvl   = 1'b1;
    logic               sda_lvl   = 1'b1;

    scan_req_t    pending_ticks[$];
    i2cs_result_t expected_reports[$];
    int unsigned  error_count = 0;
    int unsigned  rx_count    = 0;

    function automatic void load_probe();
        addr_byte = {probe_addr, 1'b0};
        sq_phase  = SQ_START_A;
        scl_lvl   = 1'b1;
        sda_lvl   = 1'b1;
        hold_cnt  = '0;
        bit_cnt   = '0;
    endfunction

    // release both lines and move on; high when the last address has been probed
    function automatic logic end_probe();
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
        if (probe_addr >= LAST_ADDR) begin
            sq_phase = SQ_IDLE;
            return 1'b1;
        end
        probe_addr = probe_addr + 1'b1;
        load_probe();
        return 1'b0;
    endfunction

    function automatic i2cs_result_t scanner_step(input logic start_req, input logic sda_seen);
        i2cs_result_t   rep;
        logic [TicksW:0] span;
        logic [TicksW:0] next_cnt;
        rep = '0;
        if (start_req) begin
            if (sq_phase == SQ_IDLE) begin
                probe_addr = FIRST_ADDR;
                load_probe();
            end
        end else if (sq_phase != SQ_IDLE) begin
            if (sq_phase == SQ_GAP)
                span = {1'b0, gap_len};
            else if (phase_len == '0)
                span = {{TicksW{1'b0}}, 1'b1};
            else
                span = {1'b0, phase_len};
            next_cnt = {1'b0, hold_cnt} + 1'b1;
            if (next_cnt < span) begin
                hold_cnt = next_cnt[TicksW-1:0];
            end else begin
                hold_cnt = '0;
                case (sq_phase)
                    SQ_START_A: begin
                        sq_phase = SQ_START_B;
                        sda_lvl  = 1'b0;
                    end
                    SQ_START_B: begin
                        sq_phase = SQ_BIT_LO;
                        scl_lvl  = 1'b0;
                        bit_cnt  = '0;
                        sda_lvl  = addr_byte[ByteW-1];
                    end
                    SQ_BIT_LO: begin
                        sq_phase = SQ_BIT_HI;
                        scl_lvl  = 1'b1;
                    end
                    SQ_BIT_HI: begin
                        addr_byte = addr_byte << 1;
                        bit_cnt   = bit_cnt + 1'b1;
                        scl_lvl   = 1'b0;
                        if (bit_cnt >= ByteW) begin
                            sq_phase = SQ_ACK_LO;
                            sda_lvl  = 1'b1;
                        end else begin
                            sq_phase = SQ_BIT_LO;
                            sda_lvl  = addr_byte[ByteW-1];
                        end
                    end
                    SQ_ACK_LO: begin
                        sq_phase = SQ_ACK_HI;
                        scl_lvl  = 1'b1;
                    end
                    SQ_ACK_HI: begin
                        if ((sel_bus == BUS_ONE || sel_bus == BUS_TWO) && !sda_seen) begin
                            rep.found_valid   = 1'b1;
                            rep.found_address = probe_addr;
                        end
                        sq_phase = SQ_STOP_LO;
                        scl_lvl  = 1'b0;
                        sda_lvl  = 1'b0;
                    end
                    SQ_STOP_LO: begin
                        sq_phase = SQ_STOP_HI;
                        scl_lvl  = 1'b1;
                    end
                    SQ_STOP_HI: begin
                        sda_lvl = 1'b1;
                        if (gap_len == '0)
                            rep.scan_done = end_probe();
                        else
                            sq_phase = SQ_GAP;
                    end
                    SQ_GAP: rep.scan_done = end_probe();
                    default: begin
                        sq_phase = SQ_IDLE;
                        scl_lvl  = 1'b1;
                        sda_lvl  = 1'b1;
                    end
                endcase
            end
        end
        rep.scl_bus1 = (sel_bus == BUS_ONE) ? scl_lvl : 1'b1;
        rep.sda_bus1 = (sel_bus == BUS_ONE) ? sda_lvl : 1'b1;
        rep.scl_bus2 = (sel_bus == BUS_TWO) ? scl_lvl : 1'b1;
        rep.sda_bus2 = (sel_bus == BUS_TWO) ? sda_lvl : 1'b1;
        rep.busy_res = (sq_phase != SQ_IDLE);
        return rep;
    endfunction

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= MAX_LINES)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [AddrW-1:0] got,
                               input logic [AddrW-1:0] want);
        if (got !== want)
            log_error($sformatf("report %0d: %s is %0h, expected %0h",
                                rx_count, name, got, want));
    endtask

    // sender: bursts of random length with random gaps between them
    int unsigned burst_left = 16;
    int unsigned gap_left   = 0;

    always @(posedge aclk) begin : stim_driver
        scan_req_t item;
        logic      offer;
        if (aresetn) begin
            offer = s_tvalid && !s_tready;   // hold the current transfer
            if (s_tvalid && s_tready)
                expected_reports.push_back(scanner_step(s_tuser, s_tdata[0]));
            if (!offer) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_ticks.size() != 0) begin
                    item     = pending_ticks.pop_front();
                    offer    = 1'b1;
                    s_tdata  <= {{(InDataW-1){1'b0}}, item.sda};
                    s_tuser  <= item.req;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        if ($urandom_range(0, 7) == 0)
                            burst_left = $urandom_range(100, 300);
                        else
                            burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            s_tvalid <= offer;
        end
    end

    // receiver: stall pattern chosen by rx_cyc[8:7], plus one long hold-off
    logic [31:0] rx_cyc    = '0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(posedge aclk) begin : result_monitor
        i2cs_result_t got;
        i2cs_result_t want;
        logic         ready_next;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                rx_count++;
                got = i2cs_result_t'(m_tdata[ResW-1:0]);
                if (m_tdata[OutDataW-1:ResW] !== '0)
                    log_error($sformatf("report %0d: padding bits set", rx_count));
                if (expected_reports.size() == 0) begin
                    log_error($sformatf("report %0d arrived with nothing expected", rx_count));
                end else begin
                    want = expected_reports.pop_front();
                    check_field("scl_bus1", AddrW'(got.scl_bus1), AddrW'(want.scl_bus1));
                    check_field("sda_bus1", AddrW'(got.sda_bus1), AddrW'(want.sda_bus1));
                    check_field("scl_bus2", AddrW'(got.scl_bus2), AddrW'(want.scl_bus2));
                    check_field("sda_bus2", AddrW'(got.sda_bus2), AddrW'(want.sda_bus2));
                    check_field("busy_res", AddrW'(got.busy_res), AddrW'(want.busy_res));
                    check_field("found_valid", AddrW'(got.found_valid),
                                AddrW'(want.found_valid));
                    check_field("found_address", got.found_address, want.found_address);
                    check_field("scan_done", AddrW'(got.scan_done), AddrW'(want.scan_done));
                end
            end
            rx_cyc <= rx_cyc + 1'b1;
            if (hold_left != 0) begin
                hold_left--;
            end else if (rx_count == HOLD_AT && !hold_done) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            case (rx_cyc[8:7])
                2'd0:    ready_next = 1'b1;
                2'd1:    ready_next = ($urandom_range(0, 3) != 0);
                2'd2:    ready_next = ($urandom_range(0, 1) != 0);
                default: ready_next = ((rx_cyc % 5) >= 2);
            endcase
            m_tready <= ready_next && (hold_left == 0);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("i2c_bitbang_address_scanner_top: mismatch");
        $finish;
    end

    task automatic queue_item(input logic req, input logic sda);
        scan_req_t item;
        item.req = req;
        item.sda = sda;
        pending_ticks.push_back(item);
    endtask

    // mostly ticks with random SDA; a start now and then, ignored while busy
    task automatic queue_random(input int n, input int start_odds);
        int i;
        @(negedge aclk);
        for (i = 0; i < n; i++)
            queue_item($urandom_range(0, start_odds - 1) == 0, 1'($urandom_range(0, 1)));
    endtask

    // hold the sender until every transfer has come back, then let the pipe settle
    task automatic wait_for_drain();
        @(negedge aclk);
        while (pending_ticks.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BUS_SELECT:  sel_bus   = val[BusSelW-1:0];
            REG_PHASE_TICKS: phase_len = val;
            REG_GAP_TICKS:   gap_len   = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [BusSelW-1:0] bus, input logic [TicksW-1:0] ph,
                              input logic [TicksW-1:0] gp);
        wait_for_drain();
        write_reg(REG_BUS_SELECT, {{(CfgDataW-BusSelW){1'b0}}, bus});
        write_reg(REG_PHASE_TICKS, ph);
        write_reg(REG_GAP_TICKS, gp);
    endtask

    initial begin : stimulus
        int i;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ticks while idle, a start, a second start while busy, a few ticks
        queue_item(1'b0, 1'b0);
        queue_item(1'b0, 1'b1);
        queue_item(1'b1, 1'b0);
        queue_item(1'b1, 1'b1);
        queue_item(1'b0, 1'b1);
        queue_item(1'b0, 1'b0);

        // shorten the phase mid-scan, no gap, no bus selected: low ack must not be found
        set_config(BUS_OFF_HIGH, '0, '0);
        @(negedge aclk);
        for (i = 0; i < 20; i++)
            queue_item(1'b0, 1'b0);

        // fastest timing: walk many probes, with starts that are ignored while busy
        set_config(BUS_ONE, 16'd1, '0);
        queue_random(700, 97);

        set_config(BUS_TWO, 16'd2, 16'd3);
        queue_random(300, 16);

        set_config(BUS_OFF_LOW, 16'd1, 16'd1);
        queue_random(150, 16);

        set_config(BUS_ONE, 16'hFFFF, 16'hFFFF);
        queue_random(100, 8);

        // phase held far longer than the new length: ends on the next tick
        set_config(BUS_TWO, 16'd3, '0);
        queue_random(200, 16);

        set_config(BUS_SELECT_RESET, PHASE_TICKS_RESET, GAP_TICKS_RESET);
        queue_random(200, 32);

        wait_for_drain();
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("i2c_bitbang_address_scanner_top: match");
        else
            $display("i2c_bitbang_address_scanner_top: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/i2cs_pkg.sv
hw/rtl/i2cs_engine.sv
hw/rtl/i2c_bitbang_address_scanner_top.sv
tb/tb_top.sv
